// ===== sv/dppfa_pkg.sv =====
// shared types and constants of the dual pool page frame allocator
package dppfa_pkg;

  localparam int unsigned FrameBits   = 36;
  localparam int unsigned PoolDepth   = 1024;
  localparam int unsigned RecordDepth = 2048;
  localparam int unsigned PageShift   = 12;

  // first frame of the high pool after reset: 2 GiB of 4 KiB pages
  localparam logic [FrameBits-1:0] BoundaryReset = FrameBits'(64'd2147483648 >> PageShift);

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_ALLOC_LO = 2'd1,
    REQ_ALLOC_HI = 2'd2,
    REQ_FREE     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e            req_type;
    logic [FrameBits-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame_out;
    status_e              status;
    logic                 fell_back;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    req_type_e            op;
    logic [FrameBits-1:0] frame;
    logic                 pool_hi;
  } cmd_t;

endpackage

// ===== sv/dppfa_ram.sv =====
// generic single port ram with registered read
module dppfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/dppfa_front.sv =====
// request intake: boundary register, pool classification and command queue
module dppfa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  dppfa_pkg::req_t                    req_i,
  input  logic                               cfg_we_i,
  input  logic [dppfa_pkg::FrameBits-1:0]    cfg_wdata_i,
  input  logic                               hold_i,
  output logic                               cmd_valid_o,
  output dppfa_pkg::cmd_t                    cmd_o,
  input  logic                               cmd_pop_i
);
  import dppfa_pkg::*;

  logic [FrameBits-1:0] boundary_q;
  cmd_t                 queue_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 accept;
  logic                 pop;
  cmd_t                 cmd_new;

  assign busy        = (cnt_q == 2'd2) | hold_i;
  assign accept      = start & ~busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    cmd_new.op      = req_i.req_type;
    cmd_new.frame   = req_i.frame;
    cmd_new.pool_hi = (req_i.frame >= boundary_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= BoundaryReset;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        boundary_q <= cfg_wdata_i;
      end
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(accept) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/dppfa_back.sv =====
// request execution: pool rings, allocation record scan and result register
module dppfa_back #(
  parameter int unsigned POOL_DEPTH   = dppfa_pkg::PoolDepth,
  parameter int unsigned RECORD_DEPTH = dppfa_pkg::RecordDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  dppfa_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            clearing_o,
  output logic            strobe_o,
  output dppfa_pkg::rsp_t rsp_o
);
  import dppfa_pkg::*;

  localparam int unsigned PW = $clog2(POOL_DEPTH);
  localparam int unsigned RW = $clog2(RECORD_DEPTH);
  localparam logic [PW:0] PoolFull  = (PW+1)'(POOL_DEPTH);
  localparam logic [PW-1:0] PoolLast = PW'(POOL_DEPTH - 1);
  localparam logic [RW:0] RecEnd    = (RW+1)'(RECORD_DEPTH);
  localparam logic [RW:0] RecLast   = (RW+1)'(RECORD_DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_POP_RD = 5'b01000,
    S_POP_WR = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   head_q [2];
  logic [PW-1:0]   head_d [2];
  logic [PW:0]     count_q [2];
  logic [PW:0]     count_d [2];
  logic [RW:0]     scan_idx_q, scan_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [RW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [RW-1:0]   slot_q, slot_d;
  cmd_t            cmd_q, cmd_d;
  logic            src_hi_q, src_hi_d;
  logic            fb_q, fb_d;
  logic            strobe_q, strobe_d;
  rsp_t            rsp_q, rsp_d;

  logic                 rec_we;
  logic [RW-1:0]        rec_addr;
  logic [FrameBits:0]   rec_wdata, rec_rdata;
  logic                 pool_we [2];
  logic [PW-1:0]        pool_addr;
  logic [FrameBits-1:0] pool_wdata;
  logic [FrameBits-1:0] pool_rdata [2];

  logic                 p_in, p_sc;
  logic [PW:0]          tail_sum;
  logic                 match;

  dppfa_ram #(.WIDTH(FrameBits+1), .DEPTH(RECORD_DEPTH)) u_record (
    .clk_i, .we_i(rec_we), .addr_i(rec_addr), .wdata_i(rec_wdata), .rdata_o(rec_rdata)
  );
  dppfa_ram #(.WIDTH(FrameBits), .DEPTH(POOL_DEPTH)) u_low_pool (
    .clk_i, .we_i(pool_we[0]), .addr_i(pool_addr), .wdata_i(pool_wdata),
    .rdata_o(pool_rdata[0])
  );
  dppfa_ram #(.WIDTH(FrameBits), .DEPTH(POOL_DEPTH)) u_high_pool (
    .clk_i, .we_i(pool_we[1]), .addr_i(pool_addr), .wdata_i(pool_wdata),
    .rdata_o(pool_rdata[1])
  );

  assign clearing_o = (state_q == S_CLEAR);
  assign strobe_o   = strobe_q;
  assign rsp_o      = rsp_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    slot_d     = slot_q;
    cmd_d      = cmd_q;
    src_hi_d   = src_hi_q;
    fb_d       = fb_q;
    strobe_d   = 1'b0;
    rsp_d      = rsp_q;
    cmd_pop_o  = 1'b0;
    rec_we     = 1'b0;
    rec_addr   = scan_idx_q[RW-1:0];
    rec_wdata  = '0;
    pool_we[0] = 1'b0;
    pool_we[1] = 1'b0;
    pool_addr  = '0;
    pool_wdata = cmd_q.frame;
    p_in       = cmd_i.pool_hi;
    p_sc       = cmd_q.pool_hi;
    tail_sum   = {1'b0, head_q[p_in]} + count_q[p_in];
    match      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        rec_we     = 1'b1;
        scan_idx_d = scan_idx_q + (RW+1)'(1);
        if (scan_idx_q == RecLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          scan_idx_d = '0;
          case (cmd_i.op)
            REQ_LOAD: begin
              strobe_d = 1'b1;
              rsp_d    = '{frame_out: cmd_i.frame, status: ST_OK, fell_back: 1'b0};
              if (count_q[p_in] == PoolFull) begin
                rsp_d.status = ST_FULL;
              end else begin
                pool_we[p_in]  = 1'b1;
                pool_wdata     = cmd_i.frame;
                pool_addr      = (tail_sum >= PoolFull) ? PW'(tail_sum - PoolFull)
                                                        : tail_sum[PW-1:0];
                count_d[p_in]  = count_q[p_in] + (PW+1)'(1);
              end
            end
            REQ_ALLOC_LO, REQ_ALLOC_HI: begin
              if (cmd_i.op == REQ_ALLOC_HI && count_q[1] != '0) begin
                src_hi_d = 1'b1;
                fb_d     = 1'b0;
                state_d  = S_SCAN;
              end else if (count_q[0] != '0) begin
                src_hi_d = 1'b0;
                fb_d     = (cmd_i.op == REQ_ALLOC_HI);
                state_d  = S_SCAN;
              end else begin
                strobe_d = 1'b1;
                rsp_d    = '{frame_out: '0, status: ST_OOM, fell_back: 1'b0};
              end
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_q.op == REQ_FREE) begin
          match = cmp_vld_q & rec_rdata[FrameBits] &
                  (rec_rdata[FrameBits-1:0] == cmd_q.frame);
        end else begin
          match = cmp_vld_q & ~rec_rdata[FrameBits];
        end
        if (match) begin
          slot_d = cmp_idx_q;
          if (cmd_q.op == REQ_FREE) begin
            state_d  = S_IDLE;
            strobe_d = 1'b1;
            rsp_d    = '{frame_out: cmd_q.frame, status: ST_OK, fell_back: 1'b0};
            if (count_q[p_sc] == PoolFull) begin
              rsp_d.status = ST_FULL;
            end else begin
              // push onto the head of the pool and drop the record entry
              head_d[p_sc]  = (head_q[p_sc] == '0) ? PoolLast
                                                   : head_q[p_sc] - PW'(1);
              pool_addr     = head_d[p_sc];
              pool_we[p_sc] = 1'b1;
              count_d[p_sc] = count_q[p_sc] + (PW+1)'(1);
              rec_we        = 1'b1;
              rec_addr      = cmp_idx_q;
              rec_wdata     = '0;
            end
          end else begin
            state_d = S_POP_RD;
          end
        end else if (scan_idx_q != RecEnd) begin
          rec_addr   = scan_idx_q[RW-1:0];
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_idx_q[RW-1:0];
          scan_idx_d = scan_idx_q + (RW+1)'(1);
        end else if (!cmp_vld_q) begin
          state_d  = S_IDLE;
          strobe_d = 1'b1;
          if (cmd_q.op == REQ_FREE) begin
            rsp_d = '{frame_out: cmd_q.frame, status: ST_UNKNOWN, fell_back: 1'b0};
          end else begin
            rsp_d = '{frame_out: '0, status: ST_FULL, fell_back: 1'b0};
          end
        end
      end
      S_POP_RD: begin
        pool_addr = head_q[src_hi_q];
        state_d   = S_POP_WR;
      end
      S_POP_WR: begin
        rec_we            = 1'b1;
        rec_addr          = slot_q;
        rec_wdata         = {1'b1, pool_rdata[src_hi_q]};
        head_d[src_hi_q]  = (head_q[src_hi_q] == PoolLast) ? '0
                                                           : head_q[src_hi_q] + PW'(1);
        count_d[src_hi_q] = count_q[src_hi_q] - (PW+1)'(1);
        strobe_d          = 1'b1;
        rsp_d             = '{frame_out: pool_rdata[src_hi_q], status: ST_OK, fell_back: fb_q};
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      head_q[0]  <= '0;
      head_q[1]  <= '0;
      count_q[0] <= '0;
      count_q[1] <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    cmd_q     <= cmd_d;
    src_hi_q  <= src_hi_d;
    fb_q      <= fb_d;
    rsp_q     <= rsp_d;
  end

endmodule

// ===== sv/dual_pool_page_frame_allocator.sv =====
// top level of the dual pool page frame allocator
//
// a request (req_type, frame) is taken at a clock edge with start high and busy
// low. load appends a frame to the low or high pool, chosen against the
// boundary register; alloc low/high pops a pool head and records the frame;
// free looks the frame up in the allocation record and pushes it back.
// each request gives one result on rsp_o, marked by strobe for one cycle; the
// receiver cannot stall, so results are never held.
// a short command queue sits between intake and execution, so up to two
// requests can wait while one runs; busy rises when the queue is full.
// load: the request is registered in the command queue, then in the result
// register with strobe; loads can follow one per cycle while no alloc or
// free is running. alloc and free scan the single port record ram one slot a
// cycle, so their run time is set by where the first free or matching slot
// lies; an alloc with both pools empty answers like a load. out of memory,
// unknown free and full pool or record give their status codes and leave the
// state unchanged. after reset the record is cleared one slot a cycle with
// busy high; the boundary register can still be written then.
module dual_pool_page_frame_allocator #(
  parameter int unsigned POOL_DEPTH   = dppfa_pkg::PoolDepth,
  parameter int unsigned RECORD_DEPTH = dppfa_pkg::RecordDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dppfa_pkg::req_t                 req_i,
  output logic                            strobe,
  output dppfa_pkg::rsp_t                 rsp_o,
  input  logic                            cfg_we_i,
  input  logic [dppfa_pkg::FrameBits-1:0] cfg_wdata_i
);
  import dppfa_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic clearing;

  dppfa_front u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i, .cfg_we_i, .cfg_wdata_i,
    .hold_i(clearing), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  dppfa_back #(.POOL_DEPTH(POOL_DEPTH), .RECORD_DEPTH(RECORD_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .clearing_o(clearing), .strobe_o(strobe), .rsp_o
  );

endmodule
